// ===== rtl/psat_pkg.sv =====
// ----------------------------------------------------------------------------
// psat_pkg
// shared types and constants for the polygon separating axis test unit
// ----------------------------------------------------------------------------
package psat_pkg;

  localparam int FIELD_W      = 16;  // port width of a coordinate
  localparam int COORD_WIDTH  = 16;  // significant coordinate bits
  localparam int MAX_VERTICES = 16;  // vertex capacity of each polygon
  localparam int QUEUE_DEPTH  = 4;

  localparam int VIDX_W = $clog2(MAX_VERTICES);
  localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
  localparam int VERT_W = 2 * COORD_WIDTH;
  localparam int NORM_W = COORD_WIDTH + 1;
  localparam int PROD_W = COORD_WIDTH + NORM_W;
  localparam int PROJ_W = PROD_W + 1;

  typedef enum logic [1:0] {
    OP_ADD_A   = 2'b00,
    OP_CLOSE_A = 2'b01,
    OP_ADD_B   = 2'b10,
    OP_CLOSE_B = 2'b11
  } op_t;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef struct packed {
    op_t    op;
    coord_t x;
    coord_t y;
  } cmd_t;

endpackage

// ===== rtl/psat_ifs.sv =====
// ----------------------------------------------------------------------------
// psat channel interfaces
// valid/ready channels for vertex items and test results
// ----------------------------------------------------------------------------
interface psat_vtx_if;
  import psat_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      polygon_select;
  logic signed [FIELD_W-1:0] vertex_x;
  logic signed [FIELD_W-1:0] vertex_y;
  logic                      last_vertex;

  modport source (output valid, polygon_select, vertex_x, vertex_y, last_vertex,
                  input ready);
  modport sink (input valid, polygon_select, vertex_x, vertex_y, last_vertex,
                output ready);
endinterface

interface psat_res_if;
  logic valid;
  logic ready;
  logic overlapping;
  logic status;

  modport source (output valid, overlapping, status, input ready);
  modport sink (input valid, overlapping, status, output ready);
endinterface

// ===== rtl/psat_front.sv =====
// ----------------------------------------------------------------------------
// psat_front
// accepts vertex items, decodes them into commands and holds one in a register
// ----------------------------------------------------------------------------
module psat_front (
  input  logic             clk,
  input  logic             rst,
  psat_vtx_if.sink         vtx,
  output logic             cmd_valid,
  input  logic             cmd_ready,
  output psat_pkg::cmd_t   cmd
);
  import psat_pkg::*;

  logic hold_valid;
  cmd_t hold;
  cmd_t decoded;

  always_comb begin
    decoded.x = coord_t'(vtx.vertex_x[COORD_WIDTH-1:0]);
    decoded.y = coord_t'(vtx.vertex_y[COORD_WIDTH-1:0]);
    unique case ({vtx.polygon_select, vtx.last_vertex})
      2'b00:   decoded.op = OP_ADD_A;
      2'b01:   decoded.op = OP_CLOSE_A;
      2'b10:   decoded.op = OP_ADD_B;
      default: decoded.op = OP_CLOSE_B;
    endcase
  end

  assign vtx.ready = !hold_valid || cmd_ready;
  assign cmd_valid = hold_valid;
  assign cmd       = hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (vtx.ready) begin
      hold_valid <= vtx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (vtx.valid && vtx.ready) begin
      hold <= decoded;
    end
  end

endmodule

// ===== rtl/psat_queue.sv =====
// ----------------------------------------------------------------------------
// psat_queue
// small command queue between the front and the back
// ----------------------------------------------------------------------------
module psat_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  psat_pkg::cmd_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output psat_pkg::cmd_t pop_data
);
  import psat_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  cmd_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   fill;
  logic             push;
  logic             pop;

  assign push_ready = fill != (PTR_W + 1)'(QUEUE_DEPTH);
  assign pop_valid  = fill != '0;
  assign pop_data   = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== rtl/psat_back.sv =====
// ----------------------------------------------------------------------------
// psat_back
// vertex store and axis sequencer: projects both polygons on each edge normal
// ----------------------------------------------------------------------------
module psat_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  psat_pkg::cmd_t cmd,
  psat_res_if.source     res
);
  import psat_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_START = 8'b0000_0010,
    ST_EDGE0 = 8'b0000_0100,
    ST_EDGE1 = 8'b0000_1000,
    ST_EDGE2 = 8'b0001_0000,
    ST_PROJ  = 8'b0010_0000,
    ST_DRAIN = 8'b0100_0000,
    ST_DONE  = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  logic [VERT_W-1:0] mem_a [MAX_VERTICES];
  logic [VERT_W-1:0] mem_b [MAX_VERTICES];
  logic [VERT_W-1:0] rd_a;
  logic [VERT_W-1:0] rd_b;
  logic [VIDX_W-1:0] rd_addr;
  logic [VIDX_W-1:0] wr_addr;
  logic              we_a;
  logic              we_b;

  logic [CNT_W-1:0] count_a, count_a_next;
  logic [CNT_W-1:0] count_b, count_b_next;
  logic             a_closed, a_closed_next;
  logic             overflow_seen, overflow_next;
  logic [CNT_W-1:0] base_a;

  logic              axis_b;        // axis comes from an edge of polygon b
  logic [VIDX_W-1:0] edge_i;
  logic [VIDX_W-1:0] edge_j;
  logic [CNT_W-1:0]  edge_n;
  logic [VIDX_W-1:0] k;
  logic              k_b;
  logic [CNT_W-1:0]  k_n;
  logic [VERT_W-1:0] vi;
  logic [VERT_W-1:0] edge_rd;
  logic signed [NORM_W-1:0] nx;
  logic signed [NORM_W-1:0] ny;

  logic              s1_valid, s1_b, s1_first;
  logic              s2_valid, s2_b, s2_first;
  logic [VERT_W-1:0] s1_rd;
  coord_t            s1_x, s1_y;
  logic signed [PROD_W-1:0] prod_x, prod_y;
  logic signed [PROJ_W-1:0] proj;
  logic signed [PROJ_W-1:0] a_lo, a_hi, b_lo, b_hi;
  logic              separated;
  logic              overlap_res;

  logic out_valid;
  logic out_overlap;
  logic out_status;
  logic out_load;

  assign res.valid       = out_valid;
  assign res.overlapping = out_overlap;
  assign res.status      = out_status;

  assign cmd_ready = state == ST_IDLE;
  assign base_a    = a_closed ? '0 : count_a;
  assign edge_n    = axis_b ? count_b : count_a;
  assign edge_j    = ((CNT_W'(edge_i) + 1'b1) < edge_n) ? edge_i + 1'b1 : '0;
  assign k_n       = k_b ? count_b : count_a;
  assign edge_rd   = axis_b ? rd_b : rd_a;
  assign separated = !(a_hi >= b_lo && b_hi >= a_lo);
  assign out_load  = state == ST_DONE && (!out_valid || res.ready);

  always_comb begin
    unique case (state)
      ST_PROJ:  rd_addr = k;
      ST_EDGE1: rd_addr = edge_j;
      default:  rd_addr = edge_i;
    endcase
  end

  // vertex stores
  always_ff @(posedge clk) begin
    if (we_a) begin
      mem_a[wr_addr] <= {cmd.x, cmd.y};
    end
    if (we_b) begin
      mem_b[wr_addr] <= {cmd.x, cmd.y};
    end
    rd_a <= mem_a[rd_addr];
    rd_b <= mem_b[rd_addr];
  end

  always_comb begin
    state_next    = state;
    count_a_next  = count_a;
    count_b_next  = count_b;
    a_closed_next = a_closed;
    overflow_next = overflow_seen;
    we_a          = 1'b0;
    we_b          = 1'b0;
    wr_addr       = '0;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          case (cmd.op) inside
            OP_ADD_A, OP_CLOSE_A: begin
              a_closed_next = cmd.op == OP_CLOSE_A;
              wr_addr       = base_a[VIDX_W-1:0];
              if (base_a < CNT_W'(MAX_VERTICES)) begin
                we_a         = 1'b1;
                count_a_next = base_a + 1'b1;
              end else begin
                count_a_next  = base_a;
                overflow_next = 1'b1;
              end
            end
            default: begin
              wr_addr = count_b[VIDX_W-1:0];
              if (count_b < CNT_W'(MAX_VERTICES)) begin
                we_b         = 1'b1;
                count_b_next = count_b + 1'b1;
              end else begin
                overflow_next = 1'b1;
              end
              if (cmd.op == OP_CLOSE_B) begin
                state_next = ST_START;
              end
            end
          endcase
        end
      end
      ST_START: begin
        state_next = (count_a == '0 || count_b == '0) ? ST_DONE : ST_EDGE0;
      end
      ST_EDGE0: state_next = ST_EDGE1;
      ST_EDGE1: state_next = ST_EDGE2;
      ST_EDGE2: state_next = ST_PROJ;
      ST_PROJ: begin
        if (k_b && (CNT_W'(k) + 1'b1) == count_b) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!s1_valid && !s2_valid) begin
          if (separated) begin
            state_next = ST_DONE;
          end else if ((CNT_W'(edge_i) + 1'b1) < edge_n || axis_b) begin
            state_next = ST_EDGE0;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_next    = ST_IDLE;
          count_a_next  = '0;
          count_b_next  = '0;
          a_closed_next = 1'b0;
          overflow_next = 1'b0;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      count_a       <= '0;
      count_b       <= '0;
      a_closed      <= 1'b0;
      overflow_seen <= 1'b0;
      s1_valid      <= 1'b0;
      s2_valid      <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      count_a       <= count_a_next;
      count_b       <= count_b_next;
      a_closed      <= a_closed_next;
      overflow_seen <= overflow_next;
      s1_valid      <= state == ST_PROJ;
      s2_valid      <= s1_valid;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // axis sequencing and edge normal
  always_ff @(posedge clk) begin
    unique case (state)
      ST_START: begin
        axis_b      <= 1'b1;
        edge_i      <= '0;
        overlap_res <= 1'b1;
      end
      ST_EDGE1: vi <= edge_rd;
      ST_EDGE2: begin
        nx  <= NORM_W'(coord_t'(vi[COORD_WIDTH-1:0]))
             - NORM_W'(coord_t'(edge_rd[COORD_WIDTH-1:0]));
        ny  <= NORM_W'(coord_t'(edge_rd[VERT_W-1:COORD_WIDTH]))
             - NORM_W'(coord_t'(vi[VERT_W-1:COORD_WIDTH]));
        k   <= '0;
        k_b <= 1'b0;
      end
      ST_PROJ: begin
        if ((CNT_W'(k) + 1'b1) == k_n) begin
          k   <= '0;
          k_b <= 1'b1;
        end else begin
          k <= k + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (!s1_valid && !s2_valid) begin
          if (separated) begin
            overlap_res <= 1'b0;
          end else if ((CNT_W'(edge_i) + 1'b1) < edge_n) begin
            edge_i <= edge_i + 1'b1;
          end else if (axis_b) begin
            axis_b <= 1'b0;
            edge_i <= '0;
          end
        end
      end
      default: ;
    endcase
  end

  // projection pipeline: read, multiply, sum and min/max
  assign s1_rd = s1_b ? rd_b : rd_a;
  assign s1_x  = coord_t'(s1_rd[VERT_W-1:COORD_WIDTH]);
  assign s1_y  = coord_t'(s1_rd[COORD_WIDTH-1:0]);
  assign proj  = PROJ_W'(prod_x) + PROJ_W'(prod_y);

  always_ff @(posedge clk) begin
    s1_b     <= k_b;
    s1_first <= k == '0;
    s2_b     <= s1_b;
    s2_first <= s1_first;
    prod_x   <= PROD_W'(s1_x) * PROD_W'(nx);
    prod_y   <= PROD_W'(s1_y) * PROD_W'(ny);
    if (s2_valid) begin
      if (s2_b) begin
        if (s2_first || proj < b_lo) b_lo <= proj;
        if (s2_first || proj > b_hi) b_hi <= proj;
      end else begin
        if (s2_first || proj < a_lo) a_lo <= proj;
        if (s2_first || proj > a_hi) a_hi <= proj;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_overlap <= overlap_res;
      out_status  <= overflow_seen;
    end
  end

  // a test only walks axes when both polygons hold vertices
  a_axes_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EDGE0) |-> (count_a != '0 && count_b != '0))
    else $error("axis walk started with an empty polygon");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (count_a <= CNT_W'(MAX_VERTICES) && count_b <= CNT_W'(MAX_VERTICES)))
    else $error("vertex count beyond capacity");

  a_pipe_in_proj: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> (state == ST_PROJ || state == ST_DRAIN))
    else $error("projection pipeline busy outside projection");

  a_close_b_starts: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready && cmd.op == OP_CLOSE_B) |=> (state == ST_START))
    else $error("closing polygon b did not start a test");

  a_done_clears: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (count_a == '0 && count_b == '0 && !overflow_seen && out_valid))
    else $error("state not cleared after result");

endmodule

// ===== rtl/polygon_separating_axis_test_unit.sv =====
// ----------------------------------------------------------------------------
// polygon_separating_axis_test_unit
// overlap test of two convex polygons by separating axes
// ----------------------------------------------------------------------------
// Vertices are taken one per cycle into a small command queue while it has
// room, and are stored while the back end is idle. Closing polygon B starts
// the test: every edge normal of B and then of A is one axis, each axis reads
// its edge from the vertex store in states EDGE0, EDGE1 and EDGE2, streams
// every vertex through the single read port of each store and a two-stage
// multiply pipeline, and waits in a drain/compare state. The walk ends at the
// first separating axis. Vertices for the next pair queue up while a test
// runs, and a result waits in the output register; the next result loads
// only once the waiting one has been taken.
module polygon_separating_axis_test_unit (
  input  logic     clk,
  input  logic     rst,
  psat_vtx_if.sink vtx,
  psat_res_if.source res
);
  import psat_pkg::*;

  logic front_valid;
  logic front_ready;
  cmd_t front_cmd;
  logic queue_valid;
  logic queue_ready;
  cmd_t queue_cmd;

  psat_front u_front (
    .clk       (clk),
    .rst       (rst),
    .vtx       (vtx),
    .cmd_valid (front_valid),
    .cmd_ready (front_ready),
    .cmd       (front_cmd)
  );

  psat_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_data  (front_cmd),
    .pop_valid  (queue_valid),
    .pop_ready  (queue_ready),
    .pop_data   (queue_cmd)
  );

  psat_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (queue_valid),
    .cmd_ready (queue_ready),
    .cmd       (queue_cmd),
    .res       (res)
  );

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the polygon separating axis test unit
// ----------------------------------------------------------------------------
// Vertex items for polygon pairs are queued up front: a few hand-built pairs
// (empty A, extreme coordinates, A restarted after closing, zero-length
// edges, B closed while A is still open), then random pairs built from
// convex outlines, scatters, overflowing polygons and broken sequences. Each
// accepted vertex updates a local copy of both polygons; closing B computes
// the expected verdict with exact integer projections. Results are compared
// in order against those verdicts. Both sides stall in random bursts.
// ----------------------------------------------------------------------------
module tb;
  import psat_pkg::*;

  localparam int TEST_CYCLES_MAX = 2 * MAX_VERTICES * (2 * MAX_VERTICES + 6) + 2;
  localparam int DRAIN_CYCLES    = TEST_CYCLES_MAX + 64;
  localparam int WATCHDOG_LIMIT  = 8 * TEST_CYCLES_MAX;
  localparam int RANDOM_ITEMS    = 1100;
  localparam int TAIL_ITEMS      = 150;
  localparam int COORD_MIN       = -(1 << (COORD_WIDTH - 1));
  localparam int COORD_MAX       = (1 << (COORD_WIDTH - 1)) - 1;

  typedef struct packed {
    logic   sel_b;
    coord_t x;
    coord_t y;
    logic   last;
  } vertex_item_t;

  typedef struct packed {
    logic overlapping;
    logic status;
  } verdict_t;

  logic clk;
  logic rst = 1'b1;

  psat_vtx_if vtx();
  psat_res_if res();

  polygon_separating_axis_test_unit DUT (
    .clk (clk),
    .rst (rst),
    .vtx (vtx),
    .res (res)
  );

  vertex_item_t vertex_feed[$];
  verdict_t     verdicts_due[$];
  int           mismatches = 0;

  // local copy of the two polygons
  longint poly_ax[MAX_VERTICES];
  longint poly_ay[MAX_VERTICES];
  longint poly_bx[MAX_VERTICES];
  longint poly_by[MAX_VERTICES];
  int     count_a = 0;
  int     count_b = 0;
  bit     a_closed = 1'b0;
  bit     dropped_any = 1'b0;

  int src_gap = 0;
  int sink_gap = 0;
  bit src_bursts_on = 1'b1;
  bit sink_bursts_on = 1'b1;
  int src_mode_left = 0;
  int sink_mode_left = 0;
  int idle_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  // true if some edge normal of the chosen polygon splits the two vertex sets
  function automatic bit normals_separate(input bit of_b);
    int     n, i, j, k;
    longint ex, ey, nx, ny, p, alo, ahi, blo, bhi;
    n = of_b ? count_b : count_a;
    for (i = 0; i < n; i++) begin
      j = (i + 1 < n) ? i + 1 : 0;
      if (of_b) begin
        ex = poly_bx[j] - poly_bx[i];
        ey = poly_by[j] - poly_by[i];
      end else begin
        ex = poly_ax[j] - poly_ax[i];
        ey = poly_ay[j] - poly_ay[i];
      end
      nx = -ey;
      ny = ex;
      alo = 0; ahi = 0; blo = 0; bhi = 0;
      for (k = 0; k < count_a; k++) begin
        p = poly_ax[k] * nx + poly_ay[k] * ny;
        if (k == 0 || p < alo) alo = p;
        if (k == 0 || p > ahi) ahi = p;
      end
      for (k = 0; k < count_b; k++) begin
        p = poly_bx[k] * nx + poly_by[k] * ny;
        if (k == 0 || p < blo) blo = p;
        if (k == 0 || p > bhi) bhi = p;
      end
      if (!(ahi >= blo && bhi >= alo)) return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic take_vertex(input vertex_item_t v);
    verdict_t verdict;
    if (!v.sel_b) begin
      // a vertex after A was closed starts a fresh polygon A
      if (a_closed) begin
        count_a = 0;
        a_closed = 1'b0;
      end
      if (count_a < MAX_VERTICES) begin
        poly_ax[count_a] = longint'(v.x);
        poly_ay[count_a] = longint'(v.y);
        count_a++;
      end else begin
        dropped_any = 1'b1;
      end
      if (v.last) a_closed = 1'b1;
    end else begin
      if (count_b < MAX_VERTICES) begin
        poly_bx[count_b] = longint'(v.x);
        poly_by[count_b] = longint'(v.y);
        count_b++;
      end else begin
        dropped_any = 1'b1;
      end
      if (v.last) begin
        if (count_a == 0 || count_b == 0) verdict.overlapping = 1'b1;
        else verdict.overlapping = !normals_separate(1'b1) && !normals_separate(1'b0);
        verdict.status = dropped_any;
        verdicts_due = {verdicts_due, verdict};
        count_a = 0;
        count_b = 0;
        a_closed = 1'b0;
        dropped_any = 1'b0;
      end
    end
  endtask

  task automatic check_verdict();
    verdict_t want;
    if (verdicts_due.size() == 0) begin
      $error("result transfer with no verdict pending: overlapping %0b status %0b",
             res.overlapping, res.status);
      mismatches++;
    end else begin
      want = verdicts_due.pop_front();
      if (res.overlapping !== want.overlapping) begin
        $error("overlapping: expected %0b, got %0b", want.overlapping, res.overlapping);
        mismatches++;
      end
      if (res.status !== want.status) begin
        $error("status: expected %0b, got %0b", want.status, res.status);
        mismatches++;
      end
    end
  endtask

  // ---------------------------------------------------------------- stimulus

  task automatic push_vertex(input bit sel_b, input int x, input int y, input bit last);
    vertex_item_t v;
    if (x < COORD_MIN) x = COORD_MIN;
    if (x > COORD_MAX) x = COORD_MAX;
    if (y < COORD_MIN) y = COORD_MIN;
    if (y > COORD_MAX) y = COORD_MAX;
    v.sel_b = sel_b;
    v.x = coord_t'(x);
    v.y = coord_t'(y);
    v.last = last;
    vertex_feed = {vertex_feed, v};
  endtask

  // convex outline of n points along a box boundary, counterclockwise, or n
  // random points if scatter is set; repeated positions give zero-length edges
  task automatic push_shape(input bit sel_b, input int n, input int cx, input int cy,
                            input int r, input bit close, input bit scatter);
    int t[$];
    int k, side, off, px, py;
    if (scatter) begin
      for (k = 0; k < n; k++)
        push_vertex(sel_b, int'($urandom_range(0, 65535)) - 32768,
                    int'($urandom_range(0, 65535)) - 32768, close && (k == n - 1));
    end else begin
      for (k = 0; k < n; k++) t = {t, int'($urandom_range(0, 8 * r - 1))};
      t.sort();
      for (k = 0; k < n; k++) begin
        side = t[k] / (2 * r);
        off = t[k] % (2 * r);
        case (side)
          0: begin px = cx - r + off; py = cy - r; end
          1: begin px = cx + r; py = cy - r + off; end
          2: begin px = cx + r - off; py = cy + r; end
          default: begin px = cx - r; py = cy + r - off; end
        endcase
        push_vertex(sel_b, px, py, close && (k == n - 1));
      end
    end
  endtask

  function automatic int pick_radius();
    case ($urandom_range(0, 2))
      0: return int'($urandom_range(1, 20));
      1: return int'($urandom_range(21, 2000));
      default: return int'($urandom_range(2001, 16000));
    endcase
  endfunction

  function automatic int pick_count(input int min_n);
    int p;
    p = int'($urandom_range(0, 99));
    if (p < 8) return min_n;
    if (p < 14) return int'($urandom_range(MAX_VERTICES - 1, MAX_VERTICES + 3));
    return int'($urandom_range(1, 6));
  endfunction

  task automatic random_pair();
    int na, nb, ra, rb, cxa, cya, cxb, cyb, spread;
    bit close_a, b_first;
    na = pick_count(0);
    nb = pick_count(1);
    ra = pick_radius();
    rb = pick_radius();
    cxa = int'($urandom_range(0, 65535)) - 32768;
    cya = int'($urandom_range(0, 65535)) - 32768;
    // offset around the touching distance, so both verdicts are common
    spread = (ra + rb) * int'($urandom_range(0, 20)) / 10;
    cxb = cxa + int'($urandom_range(0, 2 * spread)) - spread;
    cyb = cya + int'($urandom_range(0, 2 * spread)) - spread;
    close_a = ($urandom_range(0, 9) != 0);
    b_first = ($urandom_range(0, 9) == 0);
    // a closed A that the real A replaces
    if ($urandom_range(0, 9) == 0)
      push_shape(1'b0, int'($urandom_range(1, 4)), cxb, cyb, rb, 1'b1, 1'b0);
    if (b_first && nb > 1) begin
      push_shape(1'b1, nb - 1, cxb, cyb, rb, 1'b0, $urandom_range(0, 9) == 0);
      push_shape(1'b0, na, cxa, cya, ra, close_a, $urandom_range(0, 9) == 0);
      push_shape(1'b1, 1, cxb, cyb, rb, 1'b1, 1'b0);
    end else begin
      push_shape(1'b0, na, cxa, cya, ra, close_a, $urandom_range(0, 9) == 0);
      push_shape(1'b1, nb, cxb, cyb, rb, 1'b1, $urandom_range(0, 9) == 0);
    end
  endtask

  function automatic bit tail_phase();
    return vertex_feed.size() < TAIL_ITEMS;
  endfunction

  // ---------------------------------------------------------------- driver

  always @(posedge clk) begin
    vertex_item_t v;
    if (rst) begin
      vtx.valid <= 1'b0;
      src_gap <= 0;
    end else begin
      if (vtx.valid && vtx.ready) begin
        v.sel_b = vtx.polygon_select;
        v.x = coord_t'(vtx.vertex_x);
        v.y = coord_t'(vtx.vertex_y);
        v.last = vtx.last_vertex;
        take_vertex(v);
      end
      if (!vtx.valid || vtx.ready) begin
        if (src_gap != 0 || vertex_feed.size() == 0) begin
          vtx.valid <= 1'b0;
          if (src_gap != 0) src_gap <= src_gap - 1;
        end else begin
          v = vertex_feed.pop_front();
          vtx.valid <= 1'b1;
          vtx.polygon_select <= v.sel_b;
          vtx.vertex_x <= v.x;
          vtx.vertex_y <= v.y;
          vtx.last_vertex <= v.last;
          // idle burst after this transfer
          if (!tail_phase() && src_bursts_on && $urandom_range(0, 5) == 0)
            src_gap <= int'($urandom_range(1, 17));
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
      sink_gap <= 0;
    end else begin
      if (res.valid && res.ready) check_verdict();
      if (sink_gap != 0) begin
        res.ready <= 1'b0;
        sink_gap <= sink_gap - 1;
      end else if (!tail_phase() && sink_bursts_on && $urandom_range(0, 7) == 0) begin
        res.ready <= 1'b0;
        sink_gap <= int'($urandom_range(0, 16));
      end else begin
        res.ready <= 1'b1;
      end
    end
  end

  // stretches with and without idle bursts on each side
  always @(posedge clk) begin
    if (src_mode_left == 0) begin
      src_bursts_on <= ($urandom_range(0, 2) != 0);
      src_mode_left <= int'($urandom_range(50, 400));
    end else begin
      src_mode_left <= src_mode_left - 1;
    end
    if (sink_mode_left == 0) begin
      sink_bursts_on <= ($urandom_range(0, 2) != 0);
      sink_mode_left <= int'($urandom_range(50, 400));
    end else begin
      sink_mode_left <= sink_mode_left - 1;
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst) begin
      if ((vtx.valid && vtx.ready) || (res.valid && res.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    int directed_items;
    vtx.valid = 1'b0;
    vtx.polygon_select = 1'b0;
    vtx.vertex_x = '0;
    vtx.vertex_y = '0;
    vtx.last_vertex = 1'b0;
    res.ready = 1'b0;

    // B closed with A empty
    push_vertex(1'b1, 5, -7, 1'b1);
    // extreme coordinates, A around B
    push_vertex(1'b0, COORD_MIN, COORD_MIN, 1'b0);
    push_vertex(1'b0, COORD_MAX, COORD_MIN, 1'b0);
    push_vertex(1'b0, 0, COORD_MAX, 1'b1);
    push_vertex(1'b1, -100, -100, 1'b0);
    push_vertex(1'b1, 100, -100, 1'b0);
    push_vertex(1'b1, 100, 100, 1'b0);
    push_vertex(1'b1, -100, 100, 1'b1);
    // A closed, then restarted by a new A vertex
    push_vertex(1'b0, 1, 1, 1'b0);
    push_vertex(1'b0, 2, 2, 1'b1);
    push_vertex(1'b0, 1000, 1000, 1'b0);
    push_vertex(1'b0, 2000, 1000, 1'b0);
    push_vertex(1'b0, 1500, 2000, 1'b1);
    push_vertex(1'b1, COORD_MIN, COORD_MAX, 1'b0);
    push_vertex(1'b1, -30000, COORD_MAX, 1'b0);
    push_vertex(1'b1, -31000, 30000, 1'b1);
    // zero-length edges only
    push_vertex(1'b0, 7, 7, 1'b0);
    push_vertex(1'b0, 7, 7, 1'b1);
    push_vertex(1'b1, 7, 7, 1'b1);
    // B closed while A is still open
    push_vertex(1'b0, 0, 0, 1'b0);
    push_vertex(1'b0, 10, 0, 1'b0);
    push_vertex(1'b1, 5, -5, 1'b0);
    push_vertex(1'b1, 5, 5, 1'b1);
    directed_items = vertex_feed.size();

    while (vertex_feed.size() < directed_items + RANDOM_ITEMS) random_pair();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (vertex_feed.size() != 0 || vtx.valid) @(posedge clk);
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/psat_pkg.sv
rtl/psat_ifs.sv
rtl/psat_front.sv
rtl/psat_queue.sv
rtl/psat_back.sv
rtl/polygon_separating_axis_test_unit.sv
sim/tb.sv
